/* design/chm_pkg.sv */
// Shared types and constants of the chained hash map unit.
// Used by the hash stage, both memories and the top level; depends on nothing.
package chm_pkg;

	// NUM_BUCKETS must be a power of two: the bucket index is the low bits of the hash.
	localparam int NUM_BUCKETS  = 131072;
	localparam int POOL_ENTRIES = 131072;

	localparam int KEY_W    = 40;
	localparam int KEY_CHARS = 5;
	localparam int VAL_W    = 17;
	localparam int BKT_AW   = $clog2(NUM_BUCKETS);
	localparam int ENT_AW   = $clog2(POOL_ENTRIES);
	localparam int PTR_W    = $clog2(POOL_ENTRIES + 1);
	localparam int HASH_W   = 32;

	localparam logic [HASH_W-1:0] HASH_SEED = 32'd5381;

	localparam int S_DATA_W = ((KEY_W + VAL_W + 7) / 8) * 8;
	localparam int S_USER_W = 1;
	localparam int M_DATA_W = ((VAL_W + 7) / 8) * 8;
	localparam int M_USER_W = 2;

	localparam logic REQ_INSERT = 1'b0;
	localparam logic REQ_SEARCH = 1'b1;

	typedef struct packed {
		logic              rd_en;
		logic [BKT_AW-1:0] rd_addr;
		logic              wr_en;
		logic [BKT_AW-1:0] wr_addr;
		logic [PTR_W-1:0]  wr_data;
	} bkt_req_t;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [VAL_W-1:0] value;
		logic [PTR_W-1:0] link;
	} entry_t;

	typedef struct packed {
		logic              rd_en;
		logic [ENT_AW-1:0] rd_addr;
		logic              wr_en;
		logic [ENT_AW-1:0] wr_addr;
		entry_t            wr_data;
	} ent_req_t;

endpackage

/* design/chained_hash_map_short_keys_unit.sv */
// Top level of the chained hash map: request sequencer and output register.
// Depends on chm_pkg, chm_hash, chm_bucket_store and chm_entry_store.
//
// channel  dir  tdata                               tuser
// s_*      in   key_text[39:0], new_value[56:40]    req_type[0]
// m_*      out  found_value[16:0]                   hit[0], pool_full[1]
//
// An insert passes from accept through ST_HASH, ST_HEAD and ST_OUT to the result; a
// search also walks the chain in ST_WALK, one registered entry-memory read per entry.
// After reset all NUM_BUCKETS (131072) bucket heads are cleared one per cycle, with
// s_tready low. One item is in work at a time; the next is accepted once the result
// sits in the output register, which holds while m_tready is low.
module chained_hash_map_short_keys_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [chm_pkg::S_DATA_W-1:0]   s_tdata,  // key_text, new_value, zero pad
	input  logic [chm_pkg::S_USER_W-1:0]   s_tuser,  // req_type
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [chm_pkg::M_DATA_W-1:0]   m_tdata,  // found_value, zero pad
	output logic [chm_pkg::M_USER_W-1:0]   m_tuser   // hit, pool_full
);
	import chm_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_HASH = 3'd1;
	localparam logic [2:0] ST_HEAD = 3'd2;
	localparam logic [2:0] ST_WALK = 3'd3;
	localparam logic [2:0] ST_OUT  = 3'd4;

	logic [2:0]        state_q;
	logic              req_q;
	logic [VAL_W-1:0]  value_q;
	logic [PTR_W-1:0]  pool_used_q;
	logic [VAL_W-1:0]  res_value_q;
	logic              res_hit_q;
	logic              res_full_q;
	logic              m_tvalid_q;
	logic [M_DATA_W-1:0] m_tdata_q;
	logic [M_USER_W-1:0] m_tuser_q;

	logic [KEY_W-1:0]  key_norm;
	logic [BKT_AW-1:0] bucket;
	logic [PTR_W-1:0]  head;
	logic              clr_done;
	entry_t            ent_rd;
	bkt_req_t          bkt_req;
	ent_req_t          ent_req;
	logic              accept;
	logic              pool_full;
	logic              head_ok;
	logic              link_ok;

	function automatic logic ptr_ok(input logic [PTR_W-1:0] p, input logic [PTR_W-1:0] used);
		return (p != '0) && (p <= used);
	endfunction

	assign s_tready  = (state_q == ST_IDLE) && clr_done;
	assign accept    = s_tvalid && s_tready;
	assign pool_full = pool_used_q >= PTR_W'(POOL_ENTRIES);
	assign head_ok   = ptr_ok(head, pool_used_q);
	assign link_ok   = ptr_ok(ent_rd.link, pool_used_q);

	chm_hash u_hash (
		.clk        (clk),
		.en         (accept),
		.key_in     (s_tdata[KEY_W-1:0]),
		.key_norm_q (key_norm),
		.bucket_q   (bucket)
	);

	chm_bucket_store u_bucket (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (bkt_req),
		.rd_data_q  (head),
		.clr_done_q (clr_done)
	);

	chm_entry_store u_entry (
		.clk       (clk),
		.req       (ent_req),
		.rd_data_q (ent_rd)
	);

	always_comb begin
		bkt_req         = '0;
		ent_req         = '0;
		bkt_req.rd_addr = bucket;
		bkt_req.wr_addr = bucket;
		bkt_req.wr_data = pool_used_q + 1'b1;
		ent_req.wr_addr = pool_used_q[ENT_AW-1:0];
		ent_req.wr_data = '{key: key_norm, value: value_q, link: head};
		ent_req.rd_addr = ent_rd.link[ENT_AW-1:0] - 1'b1;
		unique case (state_q)
			ST_HASH: bkt_req.rd_en = 1'b1;
			ST_HEAD: begin
				if (req_q == REQ_INSERT) begin
					bkt_req.wr_en = !pool_full;
					ent_req.wr_en = !pool_full;
				end else begin
					// start the walk at the chain head
					ent_req.rd_en   = head_ok;
					ent_req.rd_addr = head[ENT_AW-1:0] - 1'b1;
				end
			end
			ST_WALK: ent_req.rd_en = (ent_rd.key != key_norm) && link_ok;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pool_used_q <= '0;
			m_tvalid_q  <= 1'b0;
		end else begin
			if (m_tvalid_q && m_tready && state_q != ST_OUT) m_tvalid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						req_q   <= s_tuser[0];
						value_q <= s_tdata[KEY_W +: VAL_W];
						state_q <= ST_HASH;
					end
				end
				ST_HASH: state_q <= ST_HEAD;
				ST_HEAD: begin
					res_value_q <= '0;
					res_hit_q   <= 1'b0;
					res_full_q  <= 1'b0;
					if (req_q == REQ_INSERT) begin
						if (pool_full) res_full_q <= 1'b1;
						else pool_used_q <= pool_used_q + 1'b1;
						state_q <= ST_OUT;
					end else if (head_ok) begin
						state_q <= ST_WALK;
					end else begin
						state_q <= ST_OUT;
					end
				end
				ST_WALK: begin
					if (ent_rd.key == key_norm) begin
						res_value_q <= ent_rd.value;
						res_hit_q   <= 1'b1;
						state_q     <= ST_OUT;
					end else if (!link_ok) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					// hold the result until the output register is free
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= {{(M_DATA_W-VAL_W){1'b0}}, res_value_q};
						m_tuser_q  <= {res_full_q, res_hit_q};
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

`ifndef SYNTHESIS
	a_no_accept_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		!clr_done |-> !s_tready)
		else $error("item accepted during bucket clearing");

	a_pool_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pool_used_q <= PTR_W'(POOL_ENTRIES))
		else $error("pool count beyond pool size");

	a_pool_grows_on_insert: assert property (@(posedge clk) disable iff (!arst_n)
		(pool_used_q != $past(pool_used_q)) |->
		($past(state_q) == ST_HEAD && $past(req_q) == REQ_INSERT))
		else $error("pool count changed outside an insert");

	a_walk_only_search: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_WALK |-> req_q == REQ_SEARCH)
		else $error("chain walk on an insert");

	a_out_waits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT && m_tvalid_q && !m_tready) |=> state_q == ST_OUT)
		else $error("result left while output register busy");
`endif

endmodule

/* design/chm_hash.sv */
// Key normalization and djb2 bucket hash, registered on item accept.
// Depends on chm_pkg.
module chm_hash (
	input  logic                         clk,
	input  logic                         en,
	input  logic [chm_pkg::KEY_W-1:0]    key_in,
	output logic [chm_pkg::KEY_W-1:0]    key_norm_q,
	output logic [chm_pkg::BKT_AW-1:0]   bucket_q
);
	import chm_pkg::*;

	logic [KEY_W-1:0]  norm;
	logic [HASH_W-1:0] h;

	always_comb begin
		logic       alive;
		logic [7:0] c;
		alive = 1'b1;
		norm  = '0;
		h     = HASH_SEED;
		for (int i = 0; i < KEY_CHARS; i++) begin
			c = key_in[8*i +: 8];
			if (c == 8'd0) alive = 1'b0;
			if (alive) begin
				h = (h << 5) + h + {{(HASH_W-8){1'b0}}, c};
				norm[8*i +: 8] = c;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			key_norm_q <= norm;
			bucket_q   <= h[BKT_AW-1:0];
		end
	end

endmodule

/* design/chm_bucket_store.sv */
// Bucket head memory with a clearing pass after reset.
// Depends on chm_pkg.
module chm_bucket_store (
	input  logic                        clk,
	input  logic                        arst_n,
	input  chm_pkg::bkt_req_t           req,
	output logic [chm_pkg::PTR_W-1:0]   rd_data_q,
	output logic                        clr_done_q
);
	import chm_pkg::*;

	logic [PTR_W-1:0]  mem [NUM_BUCKETS];
	logic [BKT_AW-1:0] clr_addr_q;
	logic              wr_en;
	logic [BKT_AW-1:0] wr_addr;
	logic [PTR_W-1:0]  wr_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
			clr_done_q <= 1'b0;
		end else if (!clr_done_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == BKT_AW'(NUM_BUCKETS - 1)) clr_done_q <= 1'b1;
		end
	end

	always_comb begin
		if (!clr_done_q) begin
			wr_en   = 1'b1;
			wr_addr = clr_addr_q;
			wr_data = '0;
		end else begin
			wr_en   = req.wr_en;
			wr_addr = req.wr_addr;
			wr_data = req.wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		if (req.rd_en) rd_data_q <= mem[req.rd_addr];
	end

endmodule

/* design/chm_entry_store.sv */
// Entry pool memory: key, value and chain link per entry.
// Depends on chm_pkg.
module chm_entry_store (
	input  logic              clk,
	input  chm_pkg::ent_req_t req,
	output chm_pkg::entry_t   rd_data_q
);
	import chm_pkg::*;

	entry_t mem [POOL_ENTRIES];

	always_ff @(posedge clk) begin
		if (req.wr_en) mem[req.wr_addr] <= req.wr_data;
		if (req.rd_en) rd_data_q <= mem[req.rd_addr];
	end

endmodule

/* tb/tb.sv */
// Self-checking bench for the chained hash map unit: inserts and searches with a local
// shadow table that predicts every answer. Depends on chm_pkg and the unit's top level.
`timescale 1ns / 1ps

module tb;
	import chm_pkg::*;

	localparam int STALL_LIMIT = 3 * NUM_BUCKETS;
	localparam int PAD_W = S_DATA_W - KEY_W - VAL_W;

	typedef struct packed {
		logic [VAL_W-1:0] value;
		logic             hit;
		logic             full;
	} answer_t;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                s_tvalid;
	logic                s_tready;
	logic [S_DATA_W-1:0] s_tdata;   // key_text, new_value, zero pad
	logic [S_USER_W-1:0] s_tuser;   // req_type
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [M_DATA_W-1:0] m_tdata;   // found_value, zero pad
	logic [M_USER_W-1:0] m_tuser;   // hit, pool_full

	// shadow copy of the table
	bit [PTR_W-1:0] chain_head [NUM_BUCKETS];
	bit [KEY_W-1:0] stored_key [POOL_ENTRIES];
	bit [VAL_W-1:0] stored_value [POOL_ENTRIES];
	bit [PTR_W-1:0] stored_link [POOL_ENTRIES];
	int             entries_used = 0;

	answer_t pending_answers [$];
	answer_t want;
	int      errors = 0;
	int      quiet_cycles = 0;
	int      send_idle_pct = 0;
	int      recv_idle_pct = 0;

	chained_hash_map_short_keys_unit DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #2 clk = ~clk;

	// Drop every byte after the first zero byte.
	function automatic logic [KEY_W-1:0] trim_key(input logic [KEY_W-1:0] key);
		logic [KEY_W-1:0] kept;
		logic ended;
		kept = '0;
		ended = 1'b0;
		for (int i = 0; i < KEY_CHARS; i++) begin
			if (key[8*i +: 8] == 8'd0)
				ended = 1'b1;
			if (!ended)
				kept[8*i +: 8] = key[8*i +: 8];
		end
		return kept;
	endfunction

	function automatic logic [31:0] djb2_bucket(input logic [KEY_W-1:0] key);
		logic [31:0] h;
		h = HASH_SEED;
		for (int i = 0; i < KEY_CHARS; i++) begin
			if (key[8*i +: 8] != 8'd0)
				h = (h << 5) + h + {24'd0, key[8*i +: 8]};
		end
		return h % 32'(NUM_BUCKETS);
	endfunction

	// Update the shadow table and return the answer the unit must give.
	function automatic answer_t apply_request(input logic req, input logic [KEY_W-1:0] raw_key,
			input logic [VAL_W-1:0] val);
		answer_t ans;
		logic [KEY_W-1:0] key;
		logic [31:0] bkt;
		int p;
		ans = '0;
		key = trim_key(raw_key);
		bkt = djb2_bucket(key);
		if (req == REQ_INSERT) begin
			if (entries_used >= POOL_ENTRIES) begin
				ans.full = 1'b1;
			end else begin
				stored_key[entries_used] = key;
				stored_value[entries_used] = val;
				stored_link[entries_used] = chain_head[bkt];
				chain_head[bkt] = PTR_W'(entries_used + 1);
				entries_used++;
			end
		end else begin
			p = chain_head[bkt];
			while (p != 0 && p <= entries_used && !ans.hit) begin
				if (stored_key[p-1] == key) begin
					ans.hit = 1'b1;
					ans.value = stored_value[p-1];
				end else begin
					p = stored_link[p-1];
				end
			end
		end
		return ans;
	endfunction

	// Entered and left just after a falling edge; valid stays high into the next item unless it starts with idle cycles.
	task automatic send_request(input logic req, input logic [KEY_W-1:0] key,
			input logic [VAL_W-1:0] val);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= req;
		s_tdata <= {{PAD_W{1'b0}}, val, key};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		pending_answers.push_back(apply_request(req, key, val));
		@(negedge clk);
	endtask

	task automatic test_directed_cases();
		send_idle_pct = 12;
		recv_idle_pct = 82;
		send_request(REQ_SEARCH, 40'd0, 17'd0);                    // empty table
		send_request(REQ_INSERT, 40'd0, 17'h1FFFF);                // empty key
		send_request(REQ_SEARCH, 40'd0, 17'd0);
		send_request(REQ_INSERT, 40'hFF_FF_FF_FF_FF, 17'd0);       // bytes above 127
		send_request(REQ_SEARCH, 40'hFF_FF_FF_FF_FF, 17'h1FFFF);
		// "Ab" with junk after the terminator; "BA" lands in the same bucket
		send_request(REQ_INSERT, 40'hC3_5A_00_62_41, 17'd1234);
		send_request(REQ_SEARCH, 40'h00_00_00_62_41, 17'd0);
		send_request(REQ_SEARCH, 40'h00_00_00_41_42, 17'd0);
		send_request(REQ_INSERT, 40'h00_00_00_41_42, 17'd777);
		send_request(REQ_SEARCH, 40'h00_00_00_62_41, 17'd0);
		send_request(REQ_SEARCH, 40'h00_00_00_41_42, 17'd0);
		send_request(REQ_INSERT, 40'h00_00_00_62_41, 17'd4321);    // shadow older "Ab"
		send_request(REQ_SEARCH, 40'h7E_00_01_62_41, 17'h15555);
		send_request(REQ_SEARCH, 40'h00_00_00_00_41, 17'd0);
		send_request(REQ_INSERT, 40'hAA_BB_CC_DD_00, 17'd5);       // same as empty key
		send_request(REQ_SEARCH, 40'h12_34_56_78_00, 17'd0);
		send_request(REQ_SEARCH, 40'hFF_FF_FF_FF_FE, 17'd0);
		send_request(REQ_INSERT, 40'h7F_01_80_FE_20, 17'h0AAAA);
		send_request(REQ_SEARCH, 40'h7F_01_80_FE_20, 17'd0);
	endtask

	task automatic test_random_traffic();
		logic [KEY_W-1:0] key_set [16];
		int               key_len [16];
		logic [KEY_W-1:0] key;
		logic [7:0]       c0;
		logic [7:0]       c1;
		int               pl;
		int               k;
		// pairs of keys with equal djb2 hash: (c0, c1) and (c0+1, c1-33) after a shared prefix
		for (int i = 0; i < 8; i++) begin
			pl = $urandom_range(3);
			key = '0;
			for (int j = 0; j < pl; j++)
				key[8*j +: 8] = 8'($urandom_range(255, 1));
			c0 = 8'($urandom_range(254, 1));
			c1 = 8'($urandom_range(255, 34));
			key_set[2*i] = key;
			key_set[2*i][8*pl +: 16] = {c1, c0};
			key_set[2*i+1] = key;
			key_set[2*i+1][8*pl +: 16] = {c1 - 8'd33, c0 + 8'd1};
			key_len[2*i] = pl + 2;
			key_len[2*i+1] = pl + 2;
		end
		for (int phase = 0; phase < 3; phase++) begin
			send_idle_pct = (phase == 0) ? 12 : (phase == 1) ? 82 : 0;
			recv_idle_pct = (phase == 0) ? 82 : (phase == 1) ? 12 : 0;
			repeat (216) begin
				if ($urandom_range(9) < 7) begin
					k = $urandom_range(15);
					key = key_set[k];
					// junk after the terminator must not matter
					if (key_len[k] < KEY_CHARS - 1 && $urandom_range(1))
						for (int j = key_len[k] + 1; j < KEY_CHARS; j++)
							key[8*j +: 8] = 8'($urandom);
				end else begin
					key = {8'($urandom), 32'($urandom)};
					if ($urandom_range(1))
						key[8*$urandom_range(KEY_CHARS-1) +: 8] = 8'd0;
				end
				send_request(1'($urandom_range(1)), key, VAL_W'($urandom));
			end
		end
	endtask

	always @(negedge clk)
		m_tready <= ($urandom_range(99) >= recv_idle_pct);

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_answers.size() == 0) begin
				$error("result with no request pending: found_value %0h hit %0b pool_full %0b",
					m_tdata[VAL_W-1:0], m_tuser[0], m_tuser[1]);
				errors++;
			end else begin
				want = pending_answers.pop_front();
				if (m_tdata[VAL_W-1:0] !== want.value) begin
					$error("found_value: expected %0h, got %0h", want.value, m_tdata[VAL_W-1:0]);
					errors++;
				end
				if (m_tuser[0] !== want.hit) begin
					$error("hit: expected %0b, got %0b", want.hit, m_tuser[0]);
					errors++;
				end
				if (m_tuser[1] !== want.full) begin
					$error("pool_full: expected %0b, got %0b", want.full, m_tuser[1]);
					errors++;
				end
			end
		end
	end

	// Covers the bucket clear after reset as well as any hang.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("chained_hash_map_short_keys_unit verification failed");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_directed_cases();
		test_random_traffic();
		s_tvalid <= 1'b0;
		wait (pending_answers.size() == 0);
		repeat (16) @(posedge clk);
		if (errors == 0)
			$display("chained_hash_map_short_keys_unit verification clean");
		else
			$display("chained_hash_map_short_keys_unit verification failed");
		$finish;
	end

endmodule
